### sv/i2cee_pkg.sv
// Shared types, codes and bus program table for the 24Cxx EEPROM I2C master.
package i2cee_pkg;

    // Command codes on the operation field
    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_READ_BYTE  = 3'd1;
    localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
    localparam logic [2:0] OP_READ_HALF  = 3'd3;
    localparam logic [2:0] OP_WRITE_HALF = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_ACK_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_TWO_BYTE    = 2'd2;
    localparam logic [1:0] CFG_DEVICE      = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RST_HALF_PERIOD = 16'd20;
    localparam logic [15:0] RST_ACK_LIMIT   = 16'd1000;
    localparam logic        RST_TWO_BYTE    = 1'b0;
    localparam logic [7:0]  RST_DEVICE      = 8'd160;

    localparam int PHASE_W = 5;

    typedef enum logic [5:0] {
        BUS_START   = 6'b000001,
        BUS_STOP    = 6'b000010,
        BUS_SEND    = 6'b000100,
        BUS_ACK     = 6'b001000,
        BUS_RECV_LO = 6'b010000,
        BUS_RECV_HI = 6'b100000
    } bus_op_t;

    typedef struct packed {
        bus_op_t    kind;
        logic [7:0] value;
    } prog_entry_t;

    typedef struct packed {
        logic [15:0] half_period;
        logic [15:0] ack_limit;
        logic        two_byte;
        logic [7:0]  dev_write;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] address;
        logic [15:0] write_data;
        logic        sda_in;
    } item_t;

    typedef struct packed {
        logic        scl;
        logic        sda;
        logic        busy;
        logic        done;
        logic [15:0] read_data;
    } result_t;

    // Bus program in the two-byte-address layout. With a folded address the
    // sequencer skips slots 2 and 3 (ack and high address byte).
    //   0 start, 1 device, 2 ack, 3 addr hi, 4 ack, 5 addr lo, 6 ack
    //   read : 7 start, 8 device rd, 9 ack, 10 recv lo, 11 stop,
    //          12 start, 13 device rd, 14 ack, 15 recv hi, 16 stop
    //   write: 7 data lo, 8 ack, 9 data hi or stop, 10 ack, 11 stop
    function automatic prog_entry_t prog_entry(
        input logic [PHASE_W-1:0] phase,
        input logic [2:0]         op,
        input cfg_t               cfg,
        input logic [15:0]        address,
        input logic [15:0]        data
    );
        logic [7:0]  dev_r;
        logic [7:0]  dev_first;
        logic        is_read;
        prog_entry_t e;
        dev_r     = cfg.dev_write + 8'd1;
        dev_first = cfg.two_byte ? cfg.dev_write
                                 : cfg.dev_write + {4'b0000, address[10:8], 1'b0};
        is_read   = (op == OP_READ_BYTE) || (op == OP_READ_HALF);
        e.kind    = BUS_STOP;
        e.value   = 8'h00;
        case (phase) inside
            5'd0: e.kind = BUS_START;
            5'd1:
            begin
                e.kind  = BUS_SEND;
                e.value = dev_first;
            end
            5'd2, 5'd4, 5'd6: e.kind = BUS_ACK;
            5'd3:
            begin
                e.kind  = BUS_SEND;
                e.value = address[15:8];
            end
            5'd5:
            begin
                e.kind  = BUS_SEND;
                e.value = address[7:0];
            end
            default:
            begin
                if (is_read)
                begin
                    case (phase) inside
                        5'd7, 5'd12: e.kind = BUS_START;
                        5'd8, 5'd13:
                        begin
                            e.kind  = BUS_SEND;
                            e.value = dev_r;
                        end
                        5'd9, 5'd14: e.kind = BUS_ACK;
                        5'd10:       e.kind = BUS_RECV_LO;
                        5'd15:       e.kind = BUS_RECV_HI;
                        default:     e.kind = BUS_STOP;
                    endcase
                end
                else
                begin
                    case (phase) inside
                        5'd7:
                        begin
                            e.kind  = BUS_SEND;
                            e.value = data[7:0];
                        end
                        5'd8, 5'd10: e.kind = BUS_ACK;
                        5'd9:
                        begin
                            if (op == OP_WRITE_HALF)
                            begin
                                e.kind  = BUS_SEND;
                                e.value = data[15:8];
                            end
                            else
                            begin
                                e.kind = BUS_STOP;
                            end
                        end
                        default: e.kind = BUS_STOP;
                    endcase
                end
            end
        endcase
        return e;
    endfunction

    // Slot index one past the last bus operation of a command
    function automatic logic [PHASE_W-1:0] prog_end(input logic [2:0] op);
        logic [PHASE_W-1:0] n;
        case (op)
            OP_READ_BYTE:  n = 5'd12;
            OP_READ_HALF:  n = 5'd17;
            OP_WRITE_BYTE: n = 5'd10;
            OP_WRITE_HALF: n = 5'd12;
            default:       n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

### sv/i2cee_cfg.sv
// Configuration register bank of the EEPROM I2C master.
module i2cee_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_enable,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output i2cee_pkg::cfg_t    cfg
);

    i2cee_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period <= i2cee_pkg::RST_HALF_PERIOD;
            cfg_reg.ack_limit   <= i2cee_pkg::RST_ACK_LIMIT;
            cfg_reg.two_byte    <= i2cee_pkg::RST_TWO_BYTE;
            cfg_reg.dev_write   <= i2cee_pkg::RST_DEVICE;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                i2cee_pkg::CFG_HALF_PERIOD: cfg_reg.half_period <= cfg_data;
                i2cee_pkg::CFG_ACK_LIMIT:   cfg_reg.ack_limit   <= cfg_data;
                i2cee_pkg::CFG_TWO_BYTE:    cfg_reg.two_byte    <= cfg_data[0];
                i2cee_pkg::CFG_DEVICE:      cfg_reg.dev_write   <= cfg_data[7:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/i2cee_core.sv
// Bus sequencer: state registers and the one-tick step of the transaction.
module i2cee_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  i2cee_pkg::item_t      item,
    input  i2cee_pkg::cfg_t       cfg,
    output i2cee_pkg::result_t    result
);

    localparam int PW = i2cee_pkg::PHASE_W;

    logic          busy_reg, busy_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic [1:0]    sub_reg, sub_next;
    logic [3:0]    bit_reg, bit_next;
    logic [7:0]    shift_reg, shift_next;
    logic [15:0]   delay_reg, delay_next;
    logic [15:0]   poll_reg, poll_next;
    logic [2:0]    held_op_reg, held_op_next;
    logic [15:0]   held_addr_reg, held_addr_next;
    logic [15:0]   held_data_reg, held_data_next;
    logic          held_two_reg, held_two_next;
    logic [7:0]    held_dev_reg, held_dev_next;
    logic [15:0]   recv_reg, recv_next;
    logic          scl_reg, scl_next;
    logic          sda_reg, sda_next;

    logic                   start_cmd;
    logic                   done;
    logic                   op_end;
    logic                   is_read;
    logic [15:0]            rdata;
    logic [15:0]            full_delay;
    logic [15:0]            short_delay;
    logic [3:0]             bit_inc;
    i2cee_pkg::cfg_t        prog_cfg;
    i2cee_pkg::prog_entry_t entry;

    always_comb
    begin
        start_cmd = !busy_reg &&
                    ((item.operation == i2cee_pkg::OP_READ_BYTE)  ||
                     (item.operation == i2cee_pkg::OP_WRITE_BYTE) ||
                     (item.operation == i2cee_pkg::OP_READ_HALF)  ||
                     (item.operation == i2cee_pkg::OP_WRITE_HALF));

        // a new command starts executing on the tick it is taken
        busy_next      = busy_reg | start_cmd;
        held_op_next   = start_cmd ? item.operation  : held_op_reg;
        held_addr_next = start_cmd ? item.address    : held_addr_reg;
        held_data_next = start_cmd ? item.write_data : held_data_reg;
        // address layout and device byte are fixed when the command is taken
        held_two_next  = start_cmd ? cfg.two_byte    : held_two_reg;
        held_dev_next  = start_cmd ? cfg.dev_write   : held_dev_reg;
        recv_next      = start_cmd ? 16'h0000 : recv_reg;
        phase_next     = start_cmd ? '0       : phase_reg;
        sub_next       = start_cmd ? 2'd0     : sub_reg;
        bit_next       = start_cmd ? 4'd0     : bit_reg;
        delay_next     = start_cmd ? 16'h0000 : delay_reg;
        poll_next      = start_cmd ? 16'h0000 : poll_reg;
        shift_next     = start_cmd ? 8'h00    : shift_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;

        prog_cfg           = cfg;
        prog_cfg.two_byte  = held_two_next;
        prog_cfg.dev_write = held_dev_next;

        full_delay  = cfg.half_period;
        short_delay = {1'b0, cfg.half_period[15:1]};
        bit_inc     = bit_next + 4'd1;
        is_read     = (held_op_next == i2cee_pkg::OP_READ_BYTE) ||
                      (held_op_next == i2cee_pkg::OP_READ_HALF);
        entry       = i2cee_pkg::prog_entry(phase_next, held_op_next, prog_cfg,
                                            held_addr_next, held_data_next);
        done        = 1'b0;
        rdata       = 16'h0000;
        op_end      = 1'b0;

        if (busy_next)
        begin
            if (delay_next != 16'h0000)
            begin
                delay_next = delay_next - 16'd1;
            end
            else if (phase_next >= i2cee_pkg::prog_end(held_op_next))
            begin
                busy_next = 1'b0;
                done      = 1'b1;
                if (is_read)
                    rdata = recv_next;
            end
            else
            begin
                case (entry.kind)
                    i2cee_pkg::BUS_START, i2cee_pkg::BUS_STOP:
                    begin
                        case (sub_next)
                            2'd0:
                            begin
                                sda_next   = (entry.kind == i2cee_pkg::BUS_START);
                                delay_next = 16'h0000;
                                sub_next   = 2'd1;
                            end
                            2'd1:
                            begin
                                scl_next   = 1'b1;
                                delay_next = full_delay;
                                sub_next   = 2'd2;
                            end
                            2'd2:
                            begin
                                sda_next   = (entry.kind != i2cee_pkg::BUS_START);
                                delay_next = full_delay;
                                sub_next   = 2'd3;
                            end
                            default:
                            begin
                                scl_next   = 1'b0;
                                delay_next = full_delay;
                                op_end     = 1'b1;
                            end
                        endcase
                    end
                    i2cee_pkg::BUS_SEND:
                    begin
                        case (sub_next)
                            2'd0:
                            begin
                                sda_next   = entry.value[3'd7 - bit_next[2:0]];
                                delay_next = 16'h0000;
                                sub_next   = 2'd1;
                            end
                            2'd1:
                            begin
                                scl_next   = 1'b1;
                                delay_next = full_delay;
                                sub_next   = 2'd2;
                            end
                            2'd2:
                            begin
                                scl_next   = 1'b0;
                                delay_next = full_delay;
                                bit_next   = bit_inc;
                                sub_next   = (bit_inc >= 4'd8) ? 2'd3 : 2'd0;
                            end
                            default:
                            begin
                                sda_next   = 1'b1;
                                delay_next = full_delay;
                                op_end     = 1'b1;
                            end
                        endcase
                    end
                    i2cee_pkg::BUS_ACK:
                    begin
                        case (sub_next)
                            2'd0:
                            begin
                                sda_next   = 1'b1;
                                delay_next = short_delay;
                                sub_next   = 2'd1;
                            end
                            2'd1:
                            begin
                                scl_next   = 1'b1;
                                delay_next = full_delay;
                                sub_next   = 2'd2;
                                poll_next  = 16'h0000;
                            end
                            default:
                            begin
                                // keep polling while SDA is high and the limit allows
                                if (item.sda_in && (poll_next < cfg.ack_limit))
                                begin
                                    poll_next  = poll_next + 16'd1;
                                    delay_next = 16'h0000;
                                end
                                else
                                begin
                                    poll_next  = 16'h0000;
                                    scl_next   = 1'b0;
                                    delay_next = full_delay;
                                    op_end     = 1'b1;
                                end
                            end
                        endcase
                    end
                    default: // receive low or high byte
                    begin
                        case (sub_next)
                            2'd0:
                            begin
                                shift_next = {shift_next[6:0], 1'b0};
                                scl_next   = 1'b1;
                                delay_next = full_delay;
                                sub_next   = 2'd1;
                            end
                            2'd1:
                            begin
                                shift_next = shift_next | {7'b0000000, item.sda_in};
                                scl_next   = 1'b0;
                                delay_next = full_delay;
                                bit_next   = bit_inc;
                                sub_next   = (bit_inc >= 4'd8) ? 2'd2 : 2'd0;
                            end
                            default:
                            begin
                                if (entry.kind == i2cee_pkg::BUS_RECV_HI)
                                    recv_next = {shift_next, recv_next[7:0]};
                                else
                                    recv_next = {recv_next[15:8], shift_next};
                                sda_next   = 1'b1;
                                delay_next = full_delay;
                                op_end     = 1'b1;
                            end
                        endcase
                    end
                endcase

                if (op_end)
                begin
                    // folded address skips the ack and high address slots
                    if ((phase_next == 5'd1) && !held_two_next)
                        phase_next = 5'd4;
                    else
                        phase_next = phase_next + 5'd1;
                    sub_next = 2'd0;
                    bit_next = 4'd0;
                end
            end
        end

        result.scl       = scl_next;
        result.sda       = sda_next;
        result.busy      = busy_next;
        result.done      = done;
        result.read_data = rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= '0;
            sub_reg       <= 2'd0;
            bit_reg       <= 4'd0;
            shift_reg     <= 8'h00;
            delay_reg     <= 16'h0000;
            poll_reg      <= 16'h0000;
            held_op_reg   <= i2cee_pkg::OP_NONE;
            held_addr_reg <= 16'h0000;
            held_data_reg <= 16'h0000;
            held_two_reg  <= i2cee_pkg::RST_TWO_BYTE;
            held_dev_reg  <= i2cee_pkg::RST_DEVICE;
            recv_reg      <= 16'h0000;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
        end
        else if (fire)
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            delay_reg     <= delay_next;
            poll_reg      <= poll_next;
            held_op_reg   <= held_op_next;
            held_addr_reg <= held_addr_next;
            held_data_reg <= held_data_next;
            held_two_reg  <= held_two_next;
            held_dev_reg  <= held_dev_next;
            recv_reg      <= recv_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
        end
    end

endmodule

### sv/i2c_eeprom_transaction_master.sv
// Top level of the 24Cxx EEPROM I2C master: input stage, sequencer, result stage.
//
//  Channel  | Handshake                      | Word carried
//  ---------+--------------------------------+------------------------------------------
//  in       | in_valid / in_stall            | operation, address, write_data, sda_in
//  out      | out_valid / out_stall          | scl_level, sda_release, busy_res,
//           |                                | done_res, read_data
//  cfg      | cfg_write_enable               | cfg_index, cfg_data (write only)
//
// Each input word is one tick of the bus sequencer and yields exactly one output word.
// Throughput is one word per cycle while out is not stalled; each word passes through the
// input register, then the sequencer step into the result register.
// Reset loads the configuration defaults and leaves the sequencer idle with SCL and
// SDA released high.
// A stall on out holds the result register; the input register then fills and in
// raises its stall until the result is taken.
module i2c_eeprom_transaction_master
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [15:0] address,
    input  logic [15:0] write_data,
    input  logic        sda_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_level,
    output logic        sda_release,
    output logic        busy_res,
    output logic        done_res,
    output logic [15:0] read_data,

    input  logic        cfg_write_enable,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    i2cee_pkg::cfg_t    cfg;
    i2cee_pkg::item_t   in_item_reg;
    i2cee_pkg::result_t step_result;
    i2cee_pkg::result_t out_res_reg;
    logic               in_full_reg;
    logic               out_valid_reg;
    logic               step_fire;

    // Configuration registers
    i2cee_cfg u_cfg
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cfg              (cfg)
    );

    // The step runs whenever a word waits in the input register and the result
    // register is empty or being drained this cycle.
    assign step_fire = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !step_fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_item_reg.operation  <= operation;
            in_item_reg.address    <= address;
            in_item_reg.write_data <= write_data;
            in_item_reg.sda_in     <= sda_in;
        end
    end

    // Sequencer: one bus tick per word
    i2cee_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (step_fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_res_reg <= step_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_level   = out_res_reg.scl;
    assign sda_release = out_res_reg.sda;
    assign busy_res    = out_res_reg.busy;
    assign done_res    = out_res_reg.done;
    assign read_data   = out_res_reg.read_data;

    // A finished transaction is never reported as still running
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done word reports busy");

    // Read data only appears on the done word
    a_data_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> read_data == 16'h0000)
        else $error("read data outside done word");

    // A word waiting in the input register moves on once the result register drains
    a_input_drains: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && out_valid && !out_stall |=> out_valid)
        else $error("input word not stepped after output drained");

endmodule
